// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property under clock and reset
`define TCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tct assertion failed");

// valid holds until taken
`define TCT_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> vld) \
        else $error("tct valid dropped before handshake");

`endif

// ===== rtl/core/tct_pkg.sv =====
package tct_pkg;

    localparam int MAX_TRIGGERS = 64;
    localparam int IDX_W        = $clog2(MAX_TRIGGERS);
    localparam int CNT_W        = $clog2(MAX_TRIGGERS + 1);
    localparam int OUT_CNT_W    = 7;
    localparam int TIME_W       = 48;
    localparam int STA_W        = 48;
    localparam int NET_W        = 16;
    localparam int KEY_W        = STA_W + NET_W;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_PURGE  = 2'd1,
        REQ_SAVE   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef struct packed {
        logic [TIME_W-1:0] ttime;
        logic [STA_W-1:0]  station;
        logic [NET_W-1:0]  network;
        logic              big;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    // count masked to the reported width
    function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_W-1:0] tmp;
        tmp = {{OUT_CNT_W{1'b0}}, c};
        return tmp[OUT_CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/trigger_coincidence_table.sv =====
// append writes one entry unless the table is full; purge and save read every live
//   entry, and every request then runs the distinct pair scan over the n live entries,
//   all through one read port; the table takes one request at a time
// an output register holds the last result while the next request runs
// reset (rst_n, asynchronous): empty table, zero snapshot; table memory not cleared
module trigger_coincidence_table
    import tct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [TIME_W-1:0]    trigger_time,
    input  logic [STA_W-1:0]     station_code,
    input  logic [NET_W-1:0]     network_code,
    input  logic                 trigger_big,
    input  logic [TIME_W-1:0]    purge_before,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_CNT_W-1:0] live_entries,
    output logic [OUT_CNT_W-1:0] unique_stations,
    output logic [TIME_W-1:0]    saved_earliest,
    output logic                 saved_is_big,
    output logic                 dropped
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_P_RD  = 10'b0000000010,
        ST_P_WR  = 10'b0000000100,
        ST_S_RD  = 10'b0000001000,
        ST_S_CHK = 10'b0000010000,
        ST_U_RDI = 10'b0000100000,
        ST_U_LDI = 10'b0001000000,
        ST_U_RDJ = 10'b0010000000,
        ST_U_CMP = 10'b0100000000,
        ST_FIN   = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  uniq_reg, uniq_next;
    logic [TIME_W-1:0] snap_time_reg, snap_time_next;
    logic              snap_big_reg, snap_big_next;
    logic [TIME_W-1:0] acc_time_reg, acc_time_next;
    logic              acc_big_reg, acc_big_next;
    logic              drop_reg, drop_next;
    logic [TIME_W-1:0] bound_reg, bound_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              ov_reg, ov_next;
    logic [OUT_CNT_W-1:0] o_live_reg, o_live_next;
    logic [OUT_CNT_W-1:0] o_uniq_reg, o_uniq_next;
    logic [TIME_W-1:0] o_time_reg, o_time_next;
    logic              o_big_reg, o_big_next;
    logic              o_drop_reg, o_drop_next;

    mem_req_t          mreq;
    entry_t            rd_data;
    logic [KEY_W-1:0]  cmp_a, cmp_b;
    logic              cmp_eq, cmp_lt;
    logic              accept;

    tct_store u_store (
        .clk     (clk),
        .req     (mreq),
        .rd_data (rd_data)
    );

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // shared compare unit, operands chosen by state
    always_comb
    begin
        cmp_a = {{(KEY_W-TIME_W){1'b0}}, rd_data.ttime};
        cmp_b = {{(KEY_W-TIME_W){1'b0}}, bound_reg};
        unique case (state_reg)
            ST_S_CHK:
            begin
                cmp_b = {{(KEY_W-TIME_W){1'b0}}, acc_time_reg};
            end
            ST_U_CMP:
            begin
                cmp_a = {rd_data.station, rd_data.network};
                cmp_b = key_reg;
            end
            default:
            begin
                cmp_b = {{(KEY_W-TIME_W){1'b0}}, bound_reg};
            end
        endcase
    end

    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_lt = (cmp_a < cmp_b);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        uniq_next      = uniq_reg;
        snap_time_next = snap_time_reg;
        snap_big_next  = snap_big_reg;
        acc_time_next  = acc_time_reg;
        acc_big_next   = acc_big_reg;
        drop_next      = drop_reg;
        bound_next     = bound_reg;
        key_next       = key_reg;
        ov_next        = ov_reg;
        o_live_next    = o_live_reg;
        o_uniq_next    = o_uniq_reg;
        o_time_next    = o_time_reg;
        o_big_next     = o_big_reg;
        o_drop_next    = o_drop_reg;

        mreq                 = '0;
        mreq.wr_data.ttime   = trigger_time;
        mreq.wr_data.station = station_code;
        mreq.wr_data.network = network_code;
        mreq.wr_data.big     = trigger_big;
        mreq.wr_addr         = count_reg[IDX_W-1:0];
        mreq.rd_addr         = i_reg[IDX_W-1:0];

        // output register drains independently
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    drop_next  = 1'b0;
                    bound_next = purge_before;
                    i_next     = '0;
                    k_next     = '0;
                    uniq_next  = '0;
                    unique case (req_t'(req_type))
                        REQ_APPEND:
                        begin
                            if (count_reg != CNT_W'(MAX_TRIGGERS))
                            begin
                                mreq.wr_en = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                            state_next = ST_U_RDI;
                        end
                        REQ_PURGE:
                        begin
                            state_next = ST_P_RD;
                        end
                        REQ_SAVE:
                        begin
                            acc_time_next = '0;
                            acc_big_next  = 1'b0;
                            state_next    = ST_S_RD;
                        end
                        default:
                        begin
                            state_next = ST_U_RDI;
                        end
                    endcase
                end
            end
            // purge: read entry i, keep it at k if not older than the bound
            ST_P_RD:
            begin
                if (i_reg == count_reg)
                begin
                    count_next = k_reg;
                    i_next     = '0;
                    state_next = ST_U_RDI;
                end
                else
                begin
                    mreq.rd_en = 1'b1;
                    state_next = ST_P_WR;
                end
            end
            ST_P_WR:
            begin
                if (!cmp_lt)
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = k_reg[IDX_W-1:0];
                    mreq.wr_data = rd_data;
                    k_next       = k_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = ST_P_RD;
            end
            // save: running minimum and big flag
            ST_S_RD:
            begin
                if (i_reg == count_reg)
                begin
                    snap_time_next = acc_time_reg;
                    snap_big_next  = acc_big_reg;
                    i_next         = '0;
                    state_next     = ST_U_RDI;
                end
                else
                begin
                    mreq.rd_en = 1'b1;
                    state_next = ST_S_CHK;
                end
            end
            ST_S_CHK:
            begin
                if ((i_reg == '0) || cmp_lt)
                begin
                    acc_time_next = rd_data.ttime;
                end
                acc_big_next = acc_big_reg | rd_data.big;
                i_next       = i_reg + 1'b1;
                state_next   = ST_S_RD;
            end
            // distinct pairs: entry i counts if no earlier entry matches it
            ST_U_RDI:
            begin
                if (i_reg == count_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    mreq.rd_en = 1'b1;
                    state_next = ST_U_LDI;
                end
            end
            ST_U_LDI:
            begin
                key_next   = {rd_data.station, rd_data.network};
                j_next     = '0;
                state_next = ST_U_RDJ;
            end
            ST_U_RDJ:
            begin
                if (j_reg == i_reg)
                begin
                    uniq_next  = uniq_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_U_RDI;
                end
                else
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = j_reg[IDX_W-1:0];
                    state_next   = ST_U_CMP;
                end
            end
            ST_U_CMP:
            begin
                if (cmp_eq)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_U_RDI;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_U_RDJ;
                end
            end
            // hand the result over once the output register is free
            ST_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    o_live_next = to_out_cnt(count_reg);
                    o_uniq_next = to_out_cnt(uniq_reg);
                    o_time_next = snap_time_reg;
                    o_big_next  = snap_big_reg;
                    o_drop_next = drop_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            snap_time_reg <= '0;
            snap_big_reg  <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            snap_time_reg <= snap_time_next;
            snap_big_reg  <= snap_big_next;
            ov_reg        <= ov_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        uniq_reg     <= uniq_next;
        acc_time_reg <= acc_time_next;
        acc_big_reg  <= acc_big_next;
        drop_reg     <= drop_next;
        bound_reg    <= bound_next;
        key_reg      <= key_next;
        o_live_reg   <= o_live_next;
        o_uniq_reg   <= o_uniq_next;
        o_time_reg   <= o_time_next;
        o_big_reg    <= o_big_next;
        o_drop_reg   <= o_drop_next;
    end

    assign out_valid       = ov_reg;
    assign live_entries    = o_live_reg;
    assign unique_stations = o_uniq_reg;
    assign saved_earliest  = o_time_reg;
    assign saved_is_big    = o_big_reg;
    assign dropped         = o_drop_reg;

endmodule

// ===== rtl/core/tct_store.sv =====
module tct_store
    import tct_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem [MAX_TRIGGERS];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/tct_checker.sv =====
`include "assert_macros.svh"

module tct_checker
    import tct_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [OUT_CNT_W-1:0] live_entries,
    input logic [OUT_CNT_W-1:0] unique_stations,
    input logic                 dropped
);

    // result stays offered until taken
    `TCT_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready)

    // a dropped append only happens with a full table
    `TCT_ASSERT(a_drop_full, clk, rst_n, (out_valid && dropped) |-> (live_entries == OUT_CNT_W'(MAX_TRIGGERS)))

    // distinct pairs never exceed the live count
    `TCT_ASSERT(a_uniq_le, clk, rst_n, out_valid |-> (unique_stations <= live_entries))

    // a non-empty table has at least one distinct pair
    `TCT_ASSERT(a_uniq_nz, clk, rst_n, (out_valid && (live_entries != '0)) |-> (unique_stations != '0))

endmodule

bind trigger_coincidence_table tct_checker u_tct_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .live_entries    (live_entries),
    .unique_stations (unique_stations),
    .dropped         (dropped)
);
